[src/h264_rtp_packetizer_macros.svh]
// assertion macros shared by the packetizer checker
`ifndef H264_RTP_PACKETIZER_MACROS_SVH
`define H264_RTP_PACKETIZER_MACROS_SVH

// same-cycle implication, disabled during reset
`define H264RTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define H264RTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/h264rtp_pkg.sv]
// types and constants of the h.264 rtp packetizer
package h264rtp_pkg;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 120;

  localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
  localparam logic [7:0] NRI_MASK      = 8'h60;
  localparam logic [7:0] F_NRI_MASK    = 8'he0;
  localparam logic [7:0] TYPE_STAP_A   = 8'd24;
  localparam logic [7:0] TYPE_FU_A     = 8'd28;
  localparam logic [7:0] FU_START_BIT  = 8'h80;
  localparam logic [7:0] FU_END_BIT    = 8'h40;
  localparam logic [6:0] FU_PREFIX_LEN = 7'd2;
  localparam logic [6:0] STAP_PREFIX_LEN = 7'd5;

  localparam logic [10:0] RST_MAX_PKT = 11'd1400;
  localparam logic [6:0]  RST_HDR     = 7'd12;
  localparam logic [7:0]  RST_KHZ     = 8'd90;

  typedef enum logic [1:0] {
    REG_MAX_PKT = 2'd0,
    REG_HDR     = 2'd1,
    REG_KHZ     = 2'd2
  } reg_idx_t;

  typedef enum logic {
    OP_NAL  = 1'b0,
    OP_PAIR = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_FU     = 2'd1,
    KIND_STAP   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] ms;
    logic [7:0]  khz;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] prod;
  } mul_rsp_t;

endpackage

[src/h264rtp_tsmul.sv]
// shift-and-add timestamp multiplier, one multiplier bit per cycle
module h264rtp_tsmul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  h264rtp_pkg::mul_req_t req,
  output h264rtp_pkg::mul_rsp_t rsp
);
  import h264rtp_pkg::*;

  logic [31:0] acc_r, acc_nxt;
  logic [31:0] a_r, a_nxt;
  logic [7:0]  b_r, b_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt  = '0;
      a_nxt    = req.ms;
      b_nxt    = req.khz;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // the one shared adder
      if (b_r[0]) begin
        acc_nxt = acc_r + a_r;
      end
      a_nxt   = {a_r[30:0], 1'b0};
      b_nxt   = {1'b0, b_r[7:1]};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

[src/h264_rtp_packetizer.sv]
// top level of the h.264 rtp packetizer
// Turns H.264 NAL unit descriptors into RTP packet descriptors.
// Input channel in_*: one word per NAL unit (in_tuser = 0) or per SPS/PPS
// pair (in_tuser = 1), in_tlast = last NAL of the access unit.
// Output channel out_*: one word per RTP packet; out_tuser is the packet
// kind (single, FU-A, STAP-A) and out_tlast marks the final packet of the
// input word. cfg_* writes max packet size, header size and clock in kHz;
// the user must write them only while the block is idle; the block does
// not enforce it. A NAL word runs through the shift-and-add timestamp
// multiplier (one multiplier bit per cycle); once the product is taken,
// its packet words go to out_*, one packet word per cycle as long as the
// receiver takes them. An SPS/PPS pair with a nonzero size moves the block
// to the emit state, which puts its one packet word in the output register.
// in_tready is high only when no word is in work, so a new word is taken
// only once the last packet word of the previous one is in the output
// register. FU-A runs are limited to MAX_FRAGMENTS words.
// When the receiver stalls, the output register holds its word and
// descriptor generation waits. Reset clears the sequence number and
// timestamp to zero, restores register defaults and empties the block;
// the first packet after reset has sequence number 1.
module h264_rtp_packetizer #(
  parameter int MAX_FRAGMENTS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // first_byte, nal_size, pps_size, capture_time_ms
  input  logic [h264rtp_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                                in_tuser,   // operation
  input  logic                                in_tlast,   // last_in_frame
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // seq_number, rtp_timestamp, marker, prefix_first, prefix_second,
  // payload_offset, payload_length, packet_length, zero pad
  output logic [h264rtp_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [1:0]                          out_tuser,  // packet_kind
  output logic                                out_tlast,  // last_of_run
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_addr,
  input  logic [10:0]                         cfg_wdata
);
  import h264rtp_pkg::*;

  localparam int CNT_W = (MAX_FRAGMENTS > 2) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam logic [CNT_W-1:0] LAST_FRAG = CNT_W'(MAX_FRAGMENTS - 1);

  // configuration registers
  logic [10:0] max_r;
  logic [6:0]  hdr_r;
  logic [7:0]  khz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= RST_MAX_PKT;
      hdr_r <= RST_HDR;
      khz_r <= RST_KHZ;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_MAX_PKT: max_r <= cfg_wdata;
        REG_HDR:     hdr_r <= cfg_wdata[6:0];
        REG_KHZ:     khz_r <= cfg_wdata[7:0];
        default:     ;
      endcase
    end
  end

  // input fields
  logic        in_op;
  logic [7:0]  in_fb;
  logic [15:0] in_size;
  logic [15:0] in_pps;
  logic [31:0] in_ms;
  logic        in_go;
  logic        in_fits;

  assign in_op   = in_tuser;
  assign in_fb   = in_tdata[7:0];
  assign in_size = in_tdata[23:8];
  assign in_pps  = in_tdata[39:24];
  assign in_ms   = in_tdata[71:40];
  assign in_go   = in_tvalid && in_tready;
  assign in_fits = ({10'd0, hdr_r} + {1'b0, in_size}) <= {6'd0, max_r};

  // state
  state_t         state_r, state_nxt;
  kind_t          kind_r;
  logic [7:0]     fb_r;
  logic [15:0]    size_r;
  logic [15:0]    pps_r;
  logic           lif_r;
  logic [15:0]    seq_r;
  logic [31:0]    ts_r;
  logic [15:0]    rem_r;
  logic [15:0]    off_r;
  logic [CNT_W-1:0] cnt_r;
  logic           first_r;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  h264rtp_tsmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign mul_req.start = in_go && (op_t'(in_op) == OP_NAL);
  assign mul_req.ms    = in_ms;
  assign mul_req.khz   = khz_r;

  // output register
  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]         out_kind_r;
  logic               out_last_r;
  logic               emit_go;

  assign in_tready  = (state_r == ST_IDLE);
  assign emit_go    = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // descriptor for the current packet
  logic [12:0] cap_full;
  logic [10:0] cap;
  logic [15:0] frag_len;
  logic [15:0] rem_after;
  logic        frag_end;
  logic [16:0] pair_sum;
  logic [17:0] pair_plen;
  logic        d_marker;
  logic [7:0]  d_p1;
  logic [7:0]  d_p2;
  logic [15:0] d_off;
  logic [15:0] d_len;
  logic [15:0] d_plen;
  logic        d_last;
  logic [15:0] seq_next;

  always_comb begin
    cap_full  = {2'd0, max_r} - {6'd0, hdr_r} - {6'd0, FU_PREFIX_LEN};
    // too little room still moves one byte per fragment
    cap       = (cap_full[12] || cap_full == 13'd0) ? 11'd1 : cap_full[10:0];
    frag_len  = (rem_r > {5'd0, cap}) ? {5'd0, cap} : rem_r;
    rem_after = rem_r - frag_len;
    frag_end  = (rem_after == 16'd0) || (cnt_r == LAST_FRAG);
    pair_sum  = {1'b0, size_r} + {1'b0, pps_r};
    pair_plen = {11'd0, hdr_r} + {11'd0, STAP_PREFIX_LEN} + {1'b0, pair_sum};
    seq_next  = seq_r + 16'd1;
    d_marker  = 1'b0;
    d_p1      = '0;
    d_p2      = '0;
    d_off     = '0;
    d_len     = size_r;
    d_plen    = {9'd0, hdr_r} + size_r;
    d_last    = 1'b1;
    case (kind_r)
      KIND_SINGLE: begin
        d_marker = lif_r;
      end
      KIND_FU: begin
        d_marker = frag_end && lif_r;
        d_p1     = (fb_r & NRI_MASK) | TYPE_FU_A;
        d_p2     = (fb_r & NAL_TYPE_MASK) | (first_r ? FU_START_BIT : 8'd0)
                   | (frag_end ? FU_END_BIT : 8'd0);
        d_off    = off_r;
        d_len    = frag_len;
        d_plen   = {9'd0, hdr_r} + {9'd0, FU_PREFIX_LEN} + frag_len;
        d_last   = frag_end;
      end
      KIND_STAP: begin
        d_p1   = (fb_r & F_NRI_MASK) | TYPE_STAP_A;
        d_len  = pair_sum[16] ? 16'hffff : pair_sum[15:0];
        d_plen = (pair_plen[17:16] != 2'd0) ? 16'hffff : pair_plen[15:0];
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_go) begin
          if (op_t'(in_op) == OP_NAL) begin
            state_nxt = ST_MUL;
          end else if (in_size != 16'd0 || in_pps != 16'd0) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_MUL: begin
        if (mul_rsp.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go && d_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seq_r       <= '0;
      ts_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mul_rsp.done) begin
        ts_r <= mul_rsp.prod;
      end
      if (emit_go) begin
        seq_r       <= seq_next;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item fields and fragment walk
  always_ff @(posedge clk) begin
    if (in_go) begin
      fb_r    <= in_fb;
      size_r  <= in_size;
      pps_r   <= in_pps;
      lif_r   <= in_tlast;
      rem_r   <= (in_size != 16'd0) ? in_size - 16'd1 : 16'd0;
      off_r   <= 16'd1;
      cnt_r   <= '0;
      first_r <= 1'b1;
      if (op_t'(in_op) == OP_PAIR) begin
        kind_r <= KIND_STAP;
      end else if (in_fits) begin
        kind_r <= KIND_SINGLE;
      end else begin
        kind_r <= KIND_FU;
      end
    end else if (emit_go) begin
      rem_r   <= rem_after;
      off_r   <= off_r + frag_len;
      cnt_r   <= cnt_r + CNT_W'(1);
      first_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data_r <= {7'd0, d_plen, d_len, d_off, d_p2, d_p1, d_marker, ts_r, seq_next};
      out_kind_r <= kind_r;
      out_last_r <= d_last;
    end
  end

endmodule

[src/h264rtp_checker.sv]
// port-level checker for the h.264 rtp packetizer, bound to the top level
`include "h264_rtp_packetizer_macros.svh"

module h264rtp_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic [h264rtp_pkg::IN_DATA_W-1:0]   in_tdata,
  input logic                                in_tuser,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [h264rtp_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [1:0]                          out_tuser,
  input logic                                out_tlast,
  input logic                                out_tvalid,
  input logic                                out_tready
);
  import h264rtp_pkg::*;

  `H264RTP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled word changed")
  // a pair with both sizes zero gives no packet and leaves the block idle
  `H264RTP_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready && (!in_tuser || in_tdata[39:8] != 32'd0), !in_tready, "ready stayed high after a word was taken")
  `H264RTP_ASSERT_NOW(a_one_word_kinds, out_tvalid && (out_tuser == KIND_SINGLE || out_tuser == KIND_STAP), out_tlast, "single or stap word not last of run")
  `H264RTP_ASSERT_NOW(a_marker_last, out_tvalid && out_tdata[48], out_tlast, "marker before end of run")

endmodule

bind h264_rtp_packetizer h264rtp_checker u_h264rtp_checker (.*);
